// ===== rtl/eer_pkg.sv =====
package eer_pkg;

  localparam int CNT_W    = 25;
  localparam int RUN_BITS = 7;
  localparam int SUB_BITS = 4;
  localparam int ROWS_W   = 13;
  localparam int MODE_W   = 2;

  localparam logic [RUN_BITS-1:0] RUN_ESCAPE = 7'd127;
  localparam logic [SUB_BITS-1:0] SUB_XOR    = 4'hA;
  localparam logic [ROWS_W-1:0]   MAX_ROWS   = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_COUNTED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWOFOLD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FOURFOLD = 2'd3;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic REG_UPSAMPLE_MODE = 1'b0;
  localparam logic REG_CAMERA_ROWS   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [13:0] x;
    logic [13:0] y;
    logic [27:0] addr;
  } result_t;

  // Decoder frame state; at most six bits stay buffered between bytes.
  typedef struct packed {
    logic [5:0]       bitbuf;
    logic [2:0]       nbits;
    logic [CNT_W-1:0] count;
    logic             expect_sub;
    logic             done;
  } dec_state_t;

endpackage

// ===== rtl/eer_dec.sv =====
module eer_dec #(
  parameter int WIDTH_LOG2 = 12
) (
  input  eer_pkg::dec_state_t state_i,
  input  logic [7:0]          stream_byte,
  input  logic                frame_start,
  input  logic [1:0]          mode_i,
  input  logic [12:0]         rows_i,
  output eer_pkg::dec_state_t state_o,
  output eer_pkg::result_t    res0,
  output eer_pkg::result_t    res1,
  output logic                push0,
  output logic                push1
);
  import eer_pkg::*;

  localparam int ROW_W = CNT_W - WIDTH_LOG2;

  dec_state_t          st;
  logic [13:0]         b;
  logic [3:0]          n;
  logic [CNT_W-1:0]    cnt;
  logic                exp_s;
  logic                dn;
  logic                stop;
  logic                ev;
  logic [CNT_W-1:0]    ev_cnt;
  logic [3:0]          ev_s;
  logic [RUN_BITS-1:0] run;
  logic [ROWS_W-1:0]   rows;
  logic [CNT_W-1:0]    pixels;
  logic [WIDTH_LOG2-1:0] col;
  logic [ROW_W-1:0]    row;
  result_t             ev_res;
  result_t             done_res;

  // At most two codes fit in one byte plus the carried bits.
  always_comb begin
    st     = frame_start ? '0 : state_i;
    rows   = (rows_i > MAX_ROWS) ? MAX_ROWS : rows_i;
    pixels = CNT_W'({rows, {WIDTH_LOG2{1'b0}}});
    b      = 14'(st.bitbuf) | (14'(stream_byte) << st.nbits);
    n      = 4'(st.nbits) + 4'd8;
    cnt    = st.count;
    exp_s  = st.expect_sub;
    dn     = 1'b0;
    stop   = st.done;
    ev     = 1'b0;
    ev_cnt = st.count;
    ev_s   = '0;
    run    = '0;
    for (int k = 0; k < 2; k++) begin
      if (!stop) begin
        if (exp_s) begin
          if (n < 4'(SUB_BITS)) begin
            stop = 1'b1;
          end else begin
            ev     = 1'b1;
            ev_cnt = cnt;
            ev_s   = b[3:0] ^ SUB_XOR;
            b      = b >> SUB_BITS;
            n      = n - 4'(SUB_BITS);
            cnt    = cnt + 25'd1;
            exp_s  = 1'b0;
          end
        end else begin
          if (n < 4'(RUN_BITS)) begin
            stop = 1'b1;
          end else begin
            run = b[RUN_BITS-1:0];
            b   = b >> RUN_BITS;
            n   = n - 4'(RUN_BITS);
            cnt = cnt + CNT_W'(run);
            if (cnt >= pixels) begin
              // drop whatever bits remain
              dn   = 1'b1;
              b    = '0;
              n    = '0;
              stop = 1'b1;
            end else if (run != RUN_ESCAPE) begin
              exp_s = 1'b1;
            end
          end
        end
      end
    end
    if (st.done) begin
      state_o = st;
    end else begin
      state_o.bitbuf     = b[5:0];
      state_o.nbits      = n[2:0];
      state_o.count      = cnt;
      state_o.expect_sub = exp_s;
      state_o.done       = dn;
    end
  end

  assign col = ev_cnt[WIDTH_LOG2-1:0];
  assign row = ev_cnt[CNT_W-1:WIDTH_LOG2];

  always_comb begin
    ev_res.kind = KIND_EVENT;
    case (mode_i)
      MODE_TWOFOLD: begin
        ev_res.x    = 14'({col, ev_s[1]});
        ev_res.y    = 14'({row, ev_s[3]});
        ev_res.addr = 28'({row, ev_s[3], col, ev_s[1]});
      end
      MODE_FOURFOLD: begin
        ev_res.x    = 14'({col, ev_s[1:0]});
        ev_res.y    = 14'({row, ev_s[3:2]});
        ev_res.addr = 28'({row, ev_s[3:2], col, ev_s[1:0]});
      end
      default: begin
        ev_res.x    = 14'(col);
        ev_res.y    = 14'(row);
        ev_res.addr = 28'({row, col});
      end
    endcase
    done_res      = '0;
    done_res.kind = KIND_DONE;
  end

  assign push0 = ev | dn;
  assign push1 = ev & dn;
  assign res0  = ev ? ev_res : done_res;
  assign res1  = done_res;

endmodule

// ===== rtl/eer_electron_event_decoder.sv =====
// Electron-event frame decoder.
// in_*  : one encoded frame byte per transfer; tdata = stream_byte, tuser = frame_start.
//         Set frame_start on the first byte of a frame to clear the bit position and
//         the pixel counter before that byte is decoded.
// out_* : one result per transfer; tuser = result_kind (0 event, 1 frame finished),
//         tdata = event_x, event_y, frame_address from the lowest bit up.
//         A frame-finished result carries zero coordinates and address.
// cfg_* : write upsample_mode (index 0) or camera_rows (index 1) while idle.
// A byte is decoded from the input register. Throughput: one byte per cycle while the
// result queue has two free entries; a byte decodes in one pass through the unpacker
// and counter adders held between the input register and the result queue.
// A byte yielding both an event and frame-finished puts two entries in the
// four-entry result queue; the input register is held while the queue has fewer
// than two free entries, so a stalled receiver backs up into in_tready.
// Once a frame is finished, bytes are taken and dropped until frame_start.
// Reset: registers to counted mode and 4096 rows, clear frame state, empty queue.
module eer_electron_event_decoder #(
  parameter int WIDTH_LOG2 = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] stream_byte
  input  logic        in_tuser,    // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [13:0] event_x, [27:14] event_y, [55:28] frame_address
  output logic        out_tuser,   // [0] result_kind
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import eer_pkg::*;

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_start_r;
  logic [MODE_W-1:0]   mode_r;
  logic [ROWS_W-1:0]   rows_r;
  dec_state_t          st_r;
  dec_state_t          st_nxt;
  result_t             res0;
  result_t             res1;
  logic                push0;
  logic                push1;
  result_t             res_mem_r [4];
  logic [1:0]          wp_r;
  logic [1:0]          rp_r;
  logic [2:0]          fill_r;
  logic [1:0]          push_cnt;
  logic                fire;
  logic                pop;
  result_t             head;

  // Decode only when the queue can take two results.
  assign fire      = s1_valid_r && (fill_r <= 3'd2);
  assign in_tready = !s1_valid_r || fire;
  assign pop       = out_tvalid && out_tready;
  assign push_cnt  = fire ? ({1'b0, push0} + {1'b0, push1}) : 2'd0;

  eer_dec #(
    .WIDTH_LOG2(WIDTH_LOG2)
  ) u_dec (
    .state_i    (st_r),
    .stream_byte(s1_byte_r),
    .frame_start(s1_start_r),
    .mode_i     (mode_r),
    .rows_i     (rows_r),
    .state_o    (st_nxt),
    .res0       (res0),
    .res1       (res1),
    .push0      (push0),
    .push1      (push1)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COUNTED;
      rows_r <= MAX_ROWS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_UPSAMPLE_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_CAMERA_ROWS:   rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state: advance once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_r + push_cnt;
      rp_r   <= rp_r + {1'b0, pop};
      fill_r <= fill_r + {1'b0, push_cnt} - {2'b0, pop};
    end
  end

  // Result storage: event first, then frame-finished in the next slot
  always_ff @(posedge clk) begin
    if (fire && push0) begin
      res_mem_r[wp_r] <= res0;
    end
    if (fire && push1) begin
      res_mem_r[wp_r + 2'd1] <= res1;
    end
  end

  assign head       = res_mem_r[rp_r];
  assign out_tvalid = (fill_r != 3'd0);
  assign out_tuser  = head.kind;
  assign out_tdata  = {head.addr, head.y, head.x};

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import eer_pkg::*;

  // Camera width as a power of two; must match the block's parameter.
  localparam int W_LOG2 = 12;
  // A zero mode value should behave as counted mode; the package names no such code.
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd0;
  // Results of a byte reach the queue through the input register; allow slack for the queue.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_BYTES = 1900;
  localparam int PHASES = 12;

  typedef enum {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  // Predicts the results of each decoded byte and checks the block's results in order.
  class event_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [ROWS_W-1:0] rows;
    int unsigned       bitbuf;
    int unsigned       nbits;
    logic [CNT_W-1:0]  count;
    bit                want_sub;
    bit                done;
    result_t           awaited[$];
    int unsigned       errors;

    function new();
      mode = MODE_COUNTED;
      rows = MAX_ROWS;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      bitbuf = 0;
      nbits = 0;
      count = '0;
      want_sub = 0;
      done = 0;
    endfunction

    function void write_reg(logic idx, logic [ROWS_W-1:0] val);
      if (idx == REG_UPSAMPLE_MODE) begin
        mode = val[MODE_W-1:0];
      end else begin
        rows = val;
      end
    endfunction

    // Returns 1 when the byte was decoded, 0 when it was dropped after frame end.
    function bit note_byte(logic [7:0] data, logic start);
      int unsigned lim, pixels, col, row, x, y, shift;
      logic [SUB_BITS-1:0] s;
      logic [RUN_BITS-1:0] run;
      longint unsigned addr;
      result_t r;
      if (start) clear_frame();
      if (done) return 0;
      bitbuf = bitbuf | (int'(data) << nbits);
      nbits = nbits + 8;
      lim = (rows > MAX_ROWS) ? MAX_ROWS : rows;
      pixels = lim << W_LOG2;
      forever begin
        if (want_sub) begin
          if (nbits < SUB_BITS) break;
          s = bitbuf[SUB_BITS-1:0] ^ SUB_XOR;
          bitbuf = bitbuf >> SUB_BITS;
          nbits = nbits - SUB_BITS;
          col = count[W_LOG2-1:0];
          row = count >> W_LOG2;
          case (mode)
            MODE_TWOFOLD: begin
              shift = 1;
              x = (col << 1) | s[1];
              y = (row << 1) | s[3];
            end
            MODE_FOURFOLD: begin
              shift = 2;
              x = (col << 2) | s[1:0];
              y = (row << 2) | s[3:2];
            end
            default: begin
              shift = 0;
              x = col;
              y = row;
            end
          endcase
          addr = (longint'(y) << (W_LOG2 + shift)) | x;
          r.kind = KIND_EVENT;
          r.x = x[13:0];
          r.y = y[13:0];
          r.addr = addr[27:0];
          awaited.push_back(r);
          count = count + 1'b1;
          want_sub = 0;
        end else begin
          if (nbits < RUN_BITS) break;
          run = bitbuf[RUN_BITS-1:0];
          bitbuf = bitbuf >> RUN_BITS;
          nbits = nbits - RUN_BITS;
          count = count + run;
          if (count >= pixels) begin
            // frame finished: drop whatever bits remain
            done = 1;
            bitbuf = 0;
            nbits = 0;
            r.kind = KIND_DONE;
            r.x = '0;
            r.y = '0;
            r.addr = '0;
            awaited.push_back(r);
            break;
          end
          if (run != RUN_ESCAPE) want_sub = 1;
        end
      end
      bitbuf = bitbuf & 32'hFFFF;
      return 1;
    endfunction

    function void check_result(logic kind, logic [55:0] data);
      result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: result_kind %0d, tdata 0x%h", kind, data);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind) begin
        $error("result_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (data[13:0] !== want.x) begin
        $error("event_x mismatch: expected %0d, actual %0d", want.x, data[13:0]);
        errors++;
      end
      if (data[27:14] !== want.y) begin
        $error("event_y mismatch: expected %0d, actual %0d", want.y, data[27:14]);
        errors++;
      end
      if (data[55:28] !== want.addr) begin
        $error("frame_address mismatch: expected %0d, actual %0d", want.addr, data[55:28]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  event_scoreboard model;
  pace_t           pace = PACE_NONE;
  int              cycle_count = 0;
  int unsigned     sent_bytes = 0;
  // Bit packer: codes are appended least significant bit first and leave as whole bytes.
  int unsigned     pack_acc = 0;
  int unsigned     pack_n = 0;
  bit              start_next = 0;

  eer_electron_event_decoder #(
    .WIDTH_LOG2(W_LOG2)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run; the limit is several times the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Receiver side: check every result transfer, then decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_result(out_tuser, out_tdata);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !roll(pace == PACE_RECEIVER ? 80 : pace == PACE_BOTH ? 9 : 0);
    end
  end

  // Transfer one byte, idling first as the pacing asks; tvalid stays high on return.
  task automatic send_byte(logic [7:0] data, logic start);
    while (roll(pace == PACE_SENDER ? 80 : pace == PACE_BOTH ? 9 : 0)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    void'(model.note_byte(data, start));
    sent_bytes++;
  endtask

  // Append a code to the packer and send every completed byte.
  task automatic put_bits(int unsigned value, int unsigned n);
    pack_acc = pack_acc | ((value & ((1 << n) - 1)) << pack_n);
    pack_n = pack_n + n;
    while (pack_n >= 8) begin
      send_byte(pack_acc[7:0], start_next);
      start_next = 0;
      pack_acc = pack_acc >> 8;
      pack_n = pack_n - 8;
    end
  endtask

  // Pad the last partial byte with random bits.
  task automatic flush_bits();
    if (pack_n > 0) put_bits($urandom_range((1 << (8 - pack_n)) - 1, 0), 8 - pack_n);
  endtask

  // Hold the sender until every awaited result has arrived and the pipeline is quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; call only once the block is idle.
  task automatic configure(logic [MODE_W-1:0] mode, logic [ROWS_W-1:0] rows);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_UPSAMPLE_MODE;
    cfg_data  <= {{(ROWS_W-MODE_W){1'b0}}, mode};
    @(posedge clk);
    model.write_reg(REG_UPSAMPLE_MODE, {{(ROWS_W-MODE_W){1'b0}}, mode});
    cfg_index <= REG_CAMERA_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    model.write_reg(REG_CAMERA_ROWS, rows);
    cfg_wr_en <= 1'b0;
  endtask

  // One random frame: mostly well-formed codes up to the frame end, sometimes raw bytes,
  // cut short at random, followed by a little trailing noise.
  task automatic send_frame();
    int unsigned lim, pixels, total, codes, cap, run, pick;
    lim = (model.rows > MAX_ROWS) ? MAX_ROWS : model.rows;
    pixels = lim << W_LOG2;
    start_next = 1;
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(40, 1)) put_bits($urandom_range(255, 0), 8);
    end else begin
      total = 0;
      codes = 0;
      cap = $urandom_range(400, 10);
      while (total < pixels && codes < cap) begin
        pick = $urandom_range(19, 0);
        if (pick < 8) begin
          run = $urandom_range(15, 0);
        end else if (pick < 13) begin
          run = 32'(RUN_ESCAPE);
        end else if (pick < 15) begin
          run = 32'(RUN_ESCAPE) - 1;
        end else begin
          run = $urandom_range(127, 0);
        end
        put_bits(run, RUN_BITS);
        total += run;
        codes++;
        if (run != RUN_ESCAPE && total < pixels) begin
          put_bits($urandom_range(15, 0), SUB_BITS);
          total++;
        end
      end
    end
    flush_bits();
    // trailing bytes: dropped after a finished frame, occasionally a fresh frame start
    repeat ($urandom_range(3, 0)) begin
      send_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
    end
  endtask

  initial begin
    logic [MODE_W-1:0] phase_mode[PHASES] = '{
      MODE_COUNTED, MODE_TWOFOLD, MODE_FOURFOLD, MODE_ZERO, MODE_COUNTED, MODE_TWOFOLD,
      MODE_FOURFOLD, MODE_TWOFOLD, MODE_COUNTED, MODE_FOURFOLD, MODE_ZERO, MODE_TWOFOLD};
    logic [ROWS_W-1:0] phase_rows[PHASES] = '{
      13'd1, 13'd1, 13'd2, 13'd0, 13'd4096, 13'd1,
      13'd1, 13'd8191, 13'd2, 13'd1, 13'd4097, 13'd3};
    int unsigned full_pixels, escapes, goal;

    model = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: counted mode, full height. Raw extremes, then packed codes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    start_next = 1;
    put_bits(0, RUN_BITS);
    put_bits(0, SUB_BITS);
    put_bits(32'(RUN_ESCAPE), RUN_BITS);
    put_bits(32'(RUN_ESCAPE) - 1, RUN_BITS);
    put_bits(15, SUB_BITS);
    put_bits(1, RUN_BITS);
    put_bits(32'(SUB_XOR), SUB_BITS);
    flush_bits();
    settle();

    // Change mode and height mid-frame, then carry on without a frame start.
    configure(MODE_FOURFOLD, 13'd8191);
    put_bits(3, RUN_BITS);
    put_bits(5, SUB_BITS);
    put_bits(32'(RUN_ESCAPE), RUN_BITS);
    put_bits(2, RUN_BITS);
    put_bits(9, SUB_BITS);
    flush_bits();
    settle();

    // Zero rows: the first run code of each frame ends it; later bytes of that frame are dropped.
    configure(MODE_ZERO, 13'd0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b0);
    settle();

    // One-row fourfold frame: escape up to the last pixel, so the final event lands on
    // the largest column. Two leading events align the final sub-pixel code to end on
    // bit 0 of a byte, so the same byte also carries the run that finishes the frame.
    configure(MODE_FOURFOLD, 13'd1);
    full_pixels = 32'd1 << W_LOG2;
    escapes = (full_pixels - 3) / RUN_ESCAPE;
    start_next = 1;
    repeat (2) begin
      put_bits(0, RUN_BITS);
      put_bits($urandom_range(15, 0), SUB_BITS);
    end
    repeat (escapes) put_bits(32'(RUN_ESCAPE), RUN_BITS);
    put_bits((full_pixels - 3) % RUN_ESCAPE, RUN_BITS);
    put_bits(32'(4'hF ^ SUB_XOR), SUB_BITS);
    put_bits(0, RUN_BITS);
    flush_bits();
    send_byte(8'hC3, 1'b0);
    settle();

    // Random phases: a new setting and pacing each time, draining before each write.
    sent_bytes = 0;
    for (int p = 0; p < PHASES; p++) begin
      pace = PACE_NONE;
      configure(phase_mode[p], phase_rows[p]);
      pace = pace_t'(p % 4);
      goal = (p + 1) * RANDOM_BYTES / PHASES;
      do begin
        send_frame();
        if ($urandom_range(5, 0) == 0) settle();
      end while (sent_bytes < goal);
      settle();
    end

    // Results still in flight land inside the settle window; extras are flagged.
    pace = PACE_NONE;
    settle();
    if (model.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
